### rtl/lfu_kvc_pkg.sv
// Shared types and constants of the LFU key-value cache.
package lfu_kvc_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = 32;
    localparam int KEYTOT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_RST = 2'd3
    } t_cmd;

    // Operation broadcast to the row of entry cells.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_SET_VALUE = 3'd1,
        OP_FILL      = 3'd2,
        OP_BUMP      = 3'd3,
        OP_DELETE    = 3'd4,
        OP_EVICT     = 3'd5,
        OP_CLEAR     = 3'd6
    } t_cell_op;

endpackage

### rtl/lfu_req_if.sv
// Request channel of the LFU key-value cache.
interface lfu_req_if;
    logic                                    valid;
    logic                                    ready;
    lfu_kvc_pkg::t_cmd                       cmd;
    logic [lfu_kvc_pkg::DATA_W-1:0]          req_key;
    logic [lfu_kvc_pkg::DATA_W-1:0]          req_value;

    modport source (output valid, output cmd, output req_key, output req_value, input ready);
    modport sink   (input valid, input cmd, input req_key, input req_value, output ready);
endinterface

### rtl/lfu_rsp_if.sv
// Response channel of the LFU key-value cache.
interface lfu_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    found;
    logic [lfu_kvc_pkg::DATA_W-1:0]          value_out;
    logic                                    evicted;
    logic [lfu_kvc_pkg::DATA_W-1:0]          evicted_key;
    logic [lfu_kvc_pkg::CNT_W-1:0]           hit_total;
    logic [lfu_kvc_pkg::CNT_W-1:0]           access_total;
    logic [lfu_kvc_pkg::CNT_W-1:0]           set_total;
    logic [lfu_kvc_pkg::KEYTOT_W-1:0]        key_total;
    logic [lfu_kvc_pkg::CNT_W-1:0]           eviction_total;

    modport source (output valid, output found, output value_out, output evicted,
                    output evicted_key, output hit_total, output access_total,
                    output set_total, output key_total, output eviction_total,
                    input ready);
    modport sink   (input valid, input found, input value_out, input evicted,
                    input evicted_key, input hit_total, input access_total,
                    input set_total, input key_total, input eviction_total,
                    output ready);
endinterface

### rtl/lfu_kvc_cell.sv
// One table entry: valid bit, key, value, frequency and one stage of the victim search chain.
module lfu_kvc_cell #(
    parameter int ENTRIES     = 64,
    parameter int CELL_IDX    = 0,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64,
    parameter int FREQ_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfu_kvc_pkg::t_cell_op         i_op,
    input  logic                          i_sel,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic                          i_tok_vld,
    input  logic [FREQ_WIDTH-1:0]         i_tok_freq,
    input  logic [$clog2(ENTRIES)-1:0]    i_tok_idx,
    output logic                          o_tok_vld,
    output logic [FREQ_WIDTH-1:0]         o_tok_freq,
    output logic [$clog2(ENTRIES)-1:0]    o_tok_idx,
    output logic                          o_valid,
    output logic                          o_match,
    output logic [KEY_WIDTH-1:0]          o_key,
    output logic [VALUE_WIDTH-1:0]        o_value
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                   r_valid;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [FREQ_WIDTH-1:0]  r_freq;
    logic                   r_tok_vld;
    logic [FREQ_WIDTH-1:0]  r_tok_freq;
    logic [IDX_W-1:0]       r_tok_idx;
    logic                   w_act;

    assign w_act = i_sel || (i_op == lfu_kvc_pkg::OP_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_freq    <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (w_act) begin
                unique case (i_op)
                    lfu_kvc_pkg::OP_FILL: begin
                        r_valid <= 1'b1;
                        r_freq  <= '0;
                    end
                    lfu_kvc_pkg::OP_BUMP: begin
                        if (r_freq != '1) begin
                            r_freq <= r_freq + 1'b1;
                        end
                    end
                    lfu_kvc_pkg::OP_EVICT: begin
                        r_freq <= FREQ_WIDTH'(1);
                    end
                    lfu_kvc_pkg::OP_DELETE, lfu_kvc_pkg::OP_CLEAR: begin
                        r_valid <= 1'b0;
                        r_freq  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && (i_op == lfu_kvc_pkg::OP_FILL || i_op == lfu_kvc_pkg::OP_EVICT)) begin
            r_key <= i_key;
        end
        if (i_sel && (i_op == lfu_kvc_pkg::OP_FILL || i_op == lfu_kvc_pkg::OP_EVICT ||
                      i_op == lfu_kvc_pkg::OP_SET_VALUE)) begin
            r_value <= i_value;
        end
        // Strict compare keeps the earlier index on equal frequencies.
        if (i_tok_vld) begin
            if (r_freq < i_tok_freq) begin
                r_tok_freq <= r_freq;
                r_tok_idx  <= IDX_W'(CELL_IDX);
            end else begin
                r_tok_freq <= i_tok_freq;
                r_tok_idx  <= i_tok_idx;
            end
        end
    end

    assign o_tok_vld  = r_tok_vld;
    assign o_tok_freq = r_tok_freq;
    assign o_tok_idx  = r_tok_idx;
    assign o_valid    = r_valid;
    assign o_match    = r_valid && (r_key == i_key);
    assign o_key      = r_key;
    assign o_value    = r_value;

endmodule

### rtl/lfu_key_value_cache.sv
// Top level of the LFU key-value cache: request control, counters and the row of entry cells.
//
//  channel | dir | handshake     | payload
//  i_req   | in  | valid / ready | cmd, req_key, req_value
//  o_rsp   | out | valid / ready | found, value_out, evicted, evicted_key, five totals
//
// A request is captured, then its key is compared in every cell in parallel and committed.
// A set that misses on a full table first runs the minimum-frequency search, which travels
// down the cell chain one cell per cycle, then evicts the entry that search picks.
// Reset is synchronous; it empties the table and clears every counter.
// A new request is accepted while a finished result waits in the output register; the next
// commit waits until that result is taken.
module lfu_key_value_cache #(
    parameter int ENTRIES     = 64,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64,
    parameter int FREQ_WIDTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfu_req_if.sink       i_req,
    lfu_rsp_if.source     o_rsp
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int VCNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_EVICT = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    lfu_kvc_pkg::t_cmd                r_cmd;
    logic [KEY_WIDTH-1:0]             r_key;
    logic [VALUE_WIDTH-1:0]           r_value;
    logic [IDX_W-1:0]                 r_victim;

    logic [lfu_kvc_pkg::CNT_W-1:0]    r_hit, r_acc, r_set, r_evc;
    logic [VCNT_W-1:0]                r_vcnt;

    logic                             r_o_valid;
    logic                             r_o_found;
    logic [VALUE_WIDTH-1:0]           r_o_value;
    logic                             r_o_evicted;
    logic [KEY_WIDTH-1:0]             r_o_evkey;

    logic [ENTRIES-1:0]               w_valid, w_match, w_free_oh, w_vic_oh, w_sel;
    logic [KEY_WIDTH-1:0]             w_key   [ENTRIES];
    logic [VALUE_WIDTH-1:0]           w_value [ENTRIES];
    logic                             w_tok_vld  [ENTRIES+1];
    logic [FREQ_WIDTH-1:0]            w_tok_freq [ENTRIES+1];
    logic [IDX_W-1:0]                 w_tok_idx  [ENTRIES+1];

    lfu_kvc_pkg::t_cell_op            w_op;
    logic                             w_hit, w_full, w_out_free;
    logic                             w_sweep_go, w_look_done, w_evict_done;
    logic [VALUE_WIDTH-1:0]           w_hit_value;
    logic [KEY_WIDTH-1:0]             w_ev_key;

    // ---------------- cell row ----------------
    assign w_tok_vld[0]  = w_sweep_go;
    assign w_tok_freq[0] = '1;
    assign w_tok_idx[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_kvc_cell #(
            .ENTRIES     (ENTRIES),
            .CELL_IDX    (g),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .FREQ_WIDTH  (FREQ_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (w_op),
            .i_sel      (w_sel[g]),
            .i_key      (r_key),
            .i_value    (r_value),
            .i_tok_vld  (w_tok_vld[g]),
            .i_tok_freq (w_tok_freq[g]),
            .i_tok_idx  (w_tok_idx[g]),
            .o_tok_vld  (w_tok_vld[g+1]),
            .o_tok_freq (w_tok_freq[g+1]),
            .o_tok_idx  (w_tok_idx[g+1]),
            .o_valid    (w_valid[g]),
            .o_match    (w_match[g]),
            .o_key      (w_key[g]),
            .o_value    (w_value[g])
        );
        assign w_vic_oh[g] = (r_victim == IDX_W'(g));
    end

    // ---------------- lookup ----------------
    assign w_hit     = |w_match;
    assign w_full    = &w_valid;
    // Lowest clear bit of the valid vector marks the first free entry.
    assign w_free_oh = ~w_valid & (w_valid + 1'b1);

    always_comb begin
        w_hit_value = '0;
        w_ev_key    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_value = w_hit_value | (w_value[i] & {VALUE_WIDTH{w_match[i]}});
            w_ev_key    = w_ev_key | (w_key[i] & {KEY_WIDTH{w_vic_oh[i]}});
        end
    end

    assign w_out_free   = !r_o_valid || o_rsp.ready;
    assign w_sweep_go   = (r_state == ST_LOOK) && (r_cmd == lfu_kvc_pkg::CMD_SET) &&
                          !w_hit && w_full;
    assign w_look_done  = (r_state == ST_LOOK) && !w_sweep_go && w_out_free;
    assign w_evict_done = (r_state == ST_EVICT) && w_out_free;

    always_comb begin
        w_op  = lfu_kvc_pkg::OP_NONE;
        w_sel = '0;
        if (w_look_done) begin
            unique case (r_cmd)
                lfu_kvc_pkg::CMD_SET: begin
                    w_op  = w_hit ? lfu_kvc_pkg::OP_SET_VALUE : lfu_kvc_pkg::OP_FILL;
                    w_sel = w_hit ? w_match : w_free_oh;
                end
                lfu_kvc_pkg::CMD_GET: begin
                    w_op  = lfu_kvc_pkg::OP_BUMP;
                    w_sel = w_match;
                end
                lfu_kvc_pkg::CMD_DEL: begin
                    w_op  = lfu_kvc_pkg::OP_DELETE;
                    w_sel = w_match;
                end
                lfu_kvc_pkg::CMD_RST: begin
                    w_op  = lfu_kvc_pkg::OP_CLEAR;
                end
                default: begin
                end
            endcase
        end else if (w_evict_done) begin
            w_op  = lfu_kvc_pkg::OP_EVICT;
            w_sel = w_vic_oh;
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_req.valid) n_state = ST_LOOK;
            ST_LOOK: begin
                if (w_sweep_go) begin
                    n_state = ST_SWEEP;
                end else if (w_look_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: if (w_tok_vld[ENTRIES]) n_state = ST_EVICT;
            ST_EVICT: if (w_evict_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_hit     <= '0;
            r_acc     <= '0;
            r_set     <= '0;
            r_evc     <= '0;
            r_vcnt    <= '0;
        end else begin
            r_state <= n_state;
            if (w_look_done || w_evict_done) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_look_done) begin
                case (r_cmd)
                    lfu_kvc_pkg::CMD_SET: begin
                        r_set <= r_set + 1'b1;
                        if (!w_hit) begin
                            r_vcnt <= r_vcnt + 1'b1;
                        end
                    end
                    lfu_kvc_pkg::CMD_GET: begin
                        r_acc <= r_acc + 1'b1;
                        if (w_hit) begin
                            r_hit <= r_hit + 1'b1;
                        end
                    end
                    lfu_kvc_pkg::CMD_DEL: begin
                        if (w_hit) begin
                            r_vcnt <= r_vcnt - 1'b1;
                        end
                    end
                    default: begin
                        r_hit  <= '0;
                        r_acc  <= '0;
                        r_set  <= '0;
                        r_evc  <= '0;
                        r_vcnt <= '0;
                    end
                endcase
            end else if (w_evict_done) begin
                r_set <= r_set + 1'b1;
                r_evc <= r_evc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req.valid) begin
            r_cmd   <= i_req.cmd;
            r_key   <= i_req.req_key[KEY_WIDTH-1:0];
            r_value <= i_req.req_value[VALUE_WIDTH-1:0];
        end
        if (r_state == ST_SWEEP && w_tok_vld[ENTRIES]) begin
            r_victim <= w_tok_idx[ENTRIES];
        end
        if (w_look_done) begin
            r_o_found   <= w_hit && (r_cmd != lfu_kvc_pkg::CMD_RST);
            r_o_value   <= (r_cmd == lfu_kvc_pkg::CMD_GET && w_hit) ? w_hit_value : '0;
            r_o_evicted <= 1'b0;
            r_o_evkey   <= '0;
        end else if (w_evict_done) begin
            r_o_found   <= 1'b0;
            r_o_value   <= '0;
            r_o_evicted <= 1'b1;
            r_o_evkey   <= w_ev_key;
        end
    end

    // Counters change only at a commit, which waits for the output register to drain,
    // so they still match the result being shown.
    assign i_req.ready          = (r_state == ST_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.found          = r_o_found;
    assign o_rsp.value_out      = lfu_kvc_pkg::DATA_W'(r_o_value);
    assign o_rsp.evicted        = r_o_evicted;
    assign o_rsp.evicted_key    = lfu_kvc_pkg::DATA_W'(r_o_evkey);
    assign o_rsp.hit_total      = r_hit;
    assign o_rsp.access_total   = r_acc;
    assign o_rsp.set_total      = r_set;
    assign o_rsp.key_total      = lfu_kvc_pkg::KEYTOT_W'(r_vcnt);
    assign o_rsp.eviction_total = r_evc;

    // ---------------- assertions ----------------
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |-> $onehot0(w_match))
        else $error("more than one entry matches the request key");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_vcnt))
        else $error("valid entry count disagrees with the valid bits");

    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP || r_state == ST_EVICT) |-> (&w_valid))
        else $error("victim search runs on a table that is not full");

    a_token_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_vld[ENTRIES] |-> (r_state == ST_SWEEP))
        else $error("search result leaves the chain outside the search state");

endmodule

### tb/testbench.sv
// Self-checking testbench of the LFU key-value cache against a mirror of the table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 64;
    localparam int KEY_W        = 64;
    localparam int VAL_W        = 64;
    localparam int FREQ_W       = 32;
    localparam int SEGMENTS     = 6;
    localparam int SEG_ITEMS    = 150;
    localparam int POOL_DEPTH   = 128;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = ENTRIES + 16;

    typedef struct packed {
        logic                             found;
        logic [lfu_kvc_pkg::DATA_W-1:0]   value_out;
        logic                             evicted;
        logic [lfu_kvc_pkg::DATA_W-1:0]   evicted_key;
        logic [lfu_kvc_pkg::CNT_W-1:0]    hit_total;
        logic [lfu_kvc_pkg::CNT_W-1:0]    access_total;
        logic [lfu_kvc_pkg::CNT_W-1:0]    set_total;
        logic [lfu_kvc_pkg::KEYTOT_W-1:0] key_total;
        logic [lfu_kvc_pkg::CNT_W-1:0]    eviction_total;
    } t_rsp;

    class cache_checker;
        bit                            slot_used [ENTRIES];
        logic [KEY_W-1:0]              slot_key  [ENTRIES];
        logic [VAL_W-1:0]              slot_val  [ENTRIES];
        logic [FREQ_W-1:0]             slot_freq [ENTRIES];
        logic [lfu_kvc_pkg::CNT_W-1:0] hits, gets, sets, evicts;
        logic [6:0]                    held;
        t_rsp                          awaited[$];
        int                            mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_freq[i] = '0;
            end
            hits   = '0;
            gets   = '0;
            sets   = '0;
            evicts = '0;
            held   = '0;
        endfunction

        function int locate(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(lfu_kvc_pkg::t_cmd c,
                                   logic [lfu_kvc_pkg::DATA_W-1:0] key_in,
                                   logic [lfu_kvc_pkg::DATA_W-1:0] val_in);
            logic [KEY_W-1:0] key;
            logic [VAL_W-1:0] val;
            t_rsp             r;
            int               idx;
            int               victim;
            key = key_in[KEY_W-1:0];
            val = val_in[VAL_W-1:0];
            r   = '0;
            case (c)
                lfu_kvc_pkg::CMD_SET: begin
                    sets++;
                    idx = locate(key);
                    if (idx >= 0) begin
                        slot_val[idx] = val;
                        r.found = 1'b1;
                    end else begin
                        for (int i = ENTRIES - 1; i >= 0; i--)
                            if (!slot_used[i])
                                idx = i;
                        if (idx >= 0) begin
                            slot_used[idx] = 1'b1;
                            slot_key[idx]  = key;
                            slot_val[idx]  = val;
                            slot_freq[idx] = '0;
                            held++;
                        end else begin
                            // Full table: the lowest frequency loses, lowest index on ties.
                            victim = 0;
                            for (int i = 1; i < ENTRIES; i++)
                                if (slot_freq[i] < slot_freq[victim])
                                    victim = i;
                            r.evicted     = 1'b1;
                            r.evicted_key = slot_key[victim];
                            evicts++;
                            slot_key[victim]  = key;
                            slot_val[victim]  = val;
                            slot_freq[victim] = FREQ_W'(1);
                        end
                    end
                end
                lfu_kvc_pkg::CMD_GET: begin
                    gets++;
                    idx = locate(key);
                    if (idx >= 0) begin
                        hits++;
                        r.found     = 1'b1;
                        r.value_out = slot_val[idx];
                        if (slot_freq[idx] != {FREQ_W{1'b1}})
                            slot_freq[idx]++;
                    end
                end
                lfu_kvc_pkg::CMD_DEL: begin
                    idx = locate(key);
                    if (idx >= 0) begin
                        slot_used[idx] = 1'b0;
                        slot_freq[idx] = '0;
                        held--;
                        r.found = 1'b1;
                    end
                end
                default: wipe();
            endcase
            r.hit_total      = hits;
            r.access_total   = gets;
            r.set_total      = sets;
            r.key_total      = held;
            r.eviction_total = evicts;
            awaited.push_back(r);
        endfunction

        function void diff(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field,
                         exp_v, act_v);
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: response with no request pending, expected none, actual %h",
                         $realtime, got);
                return;
            end
            want = awaited.pop_front();
            diff("found",          64'(want.found),          64'(got.found));
            diff("value_out",      want.value_out,           got.value_out);
            diff("evicted",        64'(want.evicted),        64'(got.evicted));
            diff("evicted_key",    want.evicted_key,         got.evicted_key);
            diff("hit_total",      64'(want.hit_total),      64'(got.hit_total));
            diff("access_total",   64'(want.access_total),   64'(got.access_total));
            diff("set_total",      64'(want.set_total),      64'(got.set_total));
            diff("key_total",      64'(want.key_total),      64'(got.key_total));
            diff("eviction_total", 64'(want.eviction_total), 64'(got.eviction_total));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    lfu_key_value_cache #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_W),
        .VALUE_WIDTH (VAL_W),
        .FREQ_WIDTH  (FREQ_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    cache_checker                   mirror = new();
    int                             burst_left;
    int                             ready_left = 0;
    int                             quiet_cycles = 0;
    logic [lfu_kvc_pkg::DATA_W-1:0] key_pool [POOL_DEPTH];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: long ready stretches mixed with short and long stalls.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            ready_left   <= $urandom_range(0, 40);
        end else begin
            rsp_ch.ready <= 1'b0;
            ready_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                                        : $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_rsp got;
        if (i_rst_n && req_ch.valid && req_ch.ready)
            mirror.note_request(req_ch.cmd, req_ch.req_key, req_ch.req_value);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.found          = rsp_ch.found;
            got.value_out      = rsp_ch.value_out;
            got.evicted        = rsp_ch.evicted;
            got.evicted_key    = rsp_ch.evicted_key;
            got.hit_total      = rsp_ch.hit_total;
            got.access_total   = rsp_ch.access_total;
            got.set_total      = rsp_ch.set_total;
            got.key_total      = rsp_ch.key_total;
            got.eviction_total = rsp_ch.eviction_total;
            mirror.check_response(got);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic pause(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Offers one item and holds it until accepted; bursts end in a random gap.
    task automatic issue(input lfu_kvc_pkg::t_cmd c,
                         input logic [lfu_kvc_pkg::DATA_W-1:0] key,
                         input logic [lfu_kvc_pkg::DATA_W-1:0] val);
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= c;
        req_ch.req_key   <= key;
        req_ch.req_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            pause($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic random_request(input int pool_size, input bit churn);
        int                             pick;
        lfu_kvc_pkg::t_cmd              c;
        logic [lfu_kvc_pkg::DATA_W-1:0] key;
        pick = $urandom_range(0, 199);
        if (pick == 0)
            c = lfu_kvc_pkg::CMD_RST;
        else if (pick < (churn ? 120 : 80))
            c = lfu_kvc_pkg::CMD_SET;
        else if (pick < (churn ? 175 : 170))
            c = lfu_kvc_pkg::CMD_GET;
        else
            c = lfu_kvc_pkg::CMD_DEL;
        // A few keys come from outside the pool and almost always miss.
        if ($urandom_range(0, 19) == 0)
            key = {$urandom, $urandom};
        else
            key = key_pool[$urandom_range(0, pool_size - 1)];
        issue(c, key, {$urandom, $urandom});
    endtask

    initial begin
        int  pool_size;
        bit  churn;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= lfu_kvc_pkg::CMD_SET;
        req_ch.req_key   <= '0;
        req_ch.req_value <= '0;
        burst_left = $urandom_range(1, 24);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: key and value extremes, hits, misses, update, delete and reset-all.
        issue(lfu_kvc_pkg::CMD_SET, 64'h0, {64{1'b1}});
        issue(lfu_kvc_pkg::CMD_SET, {64{1'b1}}, 64'h0);
        issue(lfu_kvc_pkg::CMD_SET, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        issue(lfu_kvc_pkg::CMD_GET, 64'h0, 64'h0);
        issue(lfu_kvc_pkg::CMD_GET, {64{1'b1}}, 64'h0);
        issue(lfu_kvc_pkg::CMD_GET, 64'h5555_5555_5555_5555, 64'h0);
        issue(lfu_kvc_pkg::CMD_SET, 64'h0, 64'h0123_4567_89AB_CDEF);
        issue(lfu_kvc_pkg::CMD_GET, 64'h0, 64'h0);
        issue(lfu_kvc_pkg::CMD_DEL, {64{1'b1}}, 64'h0);
        issue(lfu_kvc_pkg::CMD_DEL, {64{1'b1}}, 64'h0);
        issue(lfu_kvc_pkg::CMD_GET, {64{1'b1}}, 64'h0);
        issue(lfu_kvc_pkg::CMD_SET, 64'h8000_0000_0000_0001, 64'hFEDC_BA98_7654_3210);
        issue(lfu_kvc_pkg::CMD_GET, 64'h8000_0000_0000_0001, 64'h0);
        issue(lfu_kvc_pkg::CMD_RST, {64{1'b1}}, {64{1'b1}});
        issue(lfu_kvc_pkg::CMD_GET, 64'h0, 64'h0);
        issue(lfu_kvc_pkg::CMD_DEL, 64'h0, 64'h0);
        issue(lfu_kvc_pkg::CMD_SET, 64'h0, {64{1'b1}});
        issue(lfu_kvc_pkg::CMD_DEL, 64'h0, 64'h0);
        issue(lfu_kvc_pkg::CMD_GET, 64'h0, 64'h0);

        // Random: small pools keep hitting, large pools fill the table and evict.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            for (int i = 2; i < POOL_DEPTH; i++)
                key_pool[i] = {$urandom, $urandom};
            churn     = seg[0];
            pool_size = churn ? $urandom_range(70, POOL_DEPTH) : $urandom_range(8, 24);
            for (int n = 0; n < SEG_ITEMS; n++)
                random_request(pool_size, churn);
        end

        pause(0);
        while (mirror.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### filelist.f
rtl/lfu_kvc_pkg.sv
rtl/lfu_req_if.sv
rtl/lfu_rsp_if.sv
rtl/lfu_kvc_cell.sv
rtl/lfu_key_value_cache.sv
tb/testbench.sv
